// ===== rtl/wave_gesture_alarm_macros.svh =====
// assertion helpers used by wave_gesture_alarm.sv
`ifndef WAVE_GESTURE_ALARM_MACROS_SVH
`define WAVE_GESTURE_ALARM_MACROS_SVH

// same-cycle implication
`define WGA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WGA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wga_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wga_pkg;

	localparam int OFF_W      = 16;
	localparam int ENTRY_W    = 2 * (OFF_W + 1);
	localparam int STEP_FLOOR = 82;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAISED    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGES   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_FRAMES  = 3'd5;

	localparam logic        RST_ENABLE        = 1'b1;
	localparam logic [5:0]  RST_WINDOW_LENGTH = 6'd16;
	localparam logic [5:0]  RST_MIN_RAISED    = 6'd6;
	localparam logic [14:0] RST_MIN_SWING     = 15'd1229;
	localparam logic [4:0]  RST_MIN_CHANGES   = 5'd2;
	localparam logic [7:0]  RST_RESET_FRAMES  = 8'd10;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} wga_state_t;

endpackage

`default_nettype wire

// ===== rtl/wga_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wga_in_if;
	import wga_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    left_raised;
	logic signed [OFF_W-1:0] left_offset;
	logic                    right_raised;
	logic signed [OFF_W-1:0] right_offset;

	modport source (output valid, left_raised, left_offset, right_raised, right_offset,
		input ready);
	modport sink (input valid, left_raised, left_offset, right_raised, right_offset,
		output ready);
endinterface

interface wga_out_if;
	logic        valid;
	logic        ready;
	logic        wave_positive;
	logic        alarm_active;
	logic        alarm_started;
	logic [5:0]  best_raised;
	logic [15:0] best_swing;
	logic [4:0]  best_changes;
	logic [7:0]  release_progress;

	modport source (output valid, wave_positive, alarm_active, alarm_started, best_raised,
		best_swing, best_changes, release_progress, input ready);
	modport sink (input valid, wave_positive, alarm_active, alarm_started, best_raised,
		best_swing, best_changes, release_progress, output ready);
endinterface

`default_nettype wire

// ===== rtl/wga_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wga_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/wga_hand.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wga_hand #(
	parameter int CNT_W = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clr,
	input  wire logic                          vld,
	input  wire logic                          raised,
	input  wire logic signed [wga_pkg::OFF_W-1:0] offset,
	input  wire logic [14:0]                   min_swing,
	output logic      [CNT_W-1:0]              raised_cnt,
	output logic      [15:0]                   swing,
	output logic      [CNT_W-1:0]              changes
);
	import wga_pkg::*;

	logic [CNT_W-1:0]        raised_cnt_q;
	logic [CNT_W-1:0]        changes_q;
	logic                    has_dir_q;
	logic                    dir_pos_q;
	logic signed [OFF_W-1:0] lo_q;
	logic signed [OFF_W-1:0] hi_q;
	logic signed [OFF_W-1:0] prev_q;

	logic signed [OFF_W:0] diff;
	logic [OFF_W:0]        mag;
	logic [OFF_W+2:0]      mag5;
	logic                  step;
	logic                  dir_pos;
	logic [OFF_W:0]        span;

	assign diff    = {offset[OFF_W-1], offset} - {prev_q[OFF_W-1], prev_q};
	assign mag     = diff[OFF_W] ? (OFF_W+1)'(-diff) : (OFF_W+1)'(diff);
	assign mag5    = {mag, 2'b00} + (OFF_W+3)'(mag);
	assign step    = (mag >= (OFF_W+1)'(STEP_FLOOR)) && (mag5 >= (OFF_W+3)'(min_swing));
	assign dir_pos = !diff[OFF_W] && (diff != '0);
	assign span    = {hi_q[OFF_W-1], hi_q} - {lo_q[OFF_W-1], lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raised_cnt_q <= '0;
			changes_q    <= '0;
			has_dir_q    <= 1'b0;
			dir_pos_q    <= 1'b0;
		end else if (clr) begin
			raised_cnt_q <= '0;
			changes_q    <= '0;
			has_dir_q    <= 1'b0;
		end else if (vld && raised) begin
			raised_cnt_q <= raised_cnt_q + 1'b1;
			if (raised_cnt_q != '0 && step) begin
				if (has_dir_q && dir_pos != dir_pos_q) begin
					changes_q <= changes_q + 1'b1;
				end
				has_dir_q <= 1'b1;
				dir_pos_q <= dir_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clr && vld && raised) begin
			prev_q <= offset;
			if (raised_cnt_q == '0) begin
				lo_q <= offset;
				hi_q <= offset;
			end else begin
				if (offset < lo_q) begin
					lo_q <= offset;
				end
				if (offset > hi_q) begin
					hi_q <= offset;
				end
			end
		end
	end

	assign raised_cnt = raised_cnt_q;
	assign changes    = changes_q;
	assign swing      = (raised_cnt_q == '0) ? 16'd0 : span[15:0];

endmodule

`default_nettype wire

// ===== rtl/wave_gesture_alarm.sv =====
// channel   dir  payload
// samples   in   left_raised, left_offset, right_raised, right_offset
// results   out  wave_positive, alarm_active, alarm_started, best_raised,
//                best_swing, best_changes, release_progress
//
// one word is in flight; the result is registered at the end of the walk over the
// held window, and the next word is taken only after that, once the block is idle
// again; the walk over the single read port of the sample ram sets how long a word
// takes
// histories need no clearing after reset: a fill count bounds every read
// a stalled result holds the block in its final state; a new word can be accepted while
// the previous result waits
`timescale 1ns / 1ps
`default_nettype none
`include "wave_gesture_alarm_macros.svh"

module wave_gesture_alarm #(
	parameter int WINDOW_MAX = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	wga_in_if.sink                              samples,
	wga_out_if.source                           results,
	input  wire logic                           wr_en,
	input  wire logic [wga_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [wga_pkg::CFG_DATA_W-1:0] wr_data
);
	import wga_pkg::*;

	localparam int W     = WINDOW_MAX;
	localparam int AW    = $clog2(W);
	localparam int CNT_W = $clog2(W + 1);
	localparam int RW    = (CNT_W > 6) ? CNT_W : 6;
	localparam int PW    = AW + 2;

	logic        enable_q;
	logic [5:0]  window_length_q;
	logic [5:0]  min_raised_q;
	logic [14:0] min_swing_q;
	logic [4:0]  min_changes_q;
	logic [7:0]  reset_frames_q;

	wga_state_t       state_q;
	logic [AW-1:0]    wp_q;
	logic [CNT_W-1:0] held_q;
	logic [CNT_W-1:0] issue_q;
	logic [AW-1:0]    rd_addr_q;
	logic             vld_s1;
	logic             alarm_q;
	logic [7:0]       streak_q;

	logic        out_valid_q;
	logic        positive_q;
	logic        active_q;
	logic        started_q;
	logic [5:0]  best_raised_q;
	logic [15:0] best_swing_q;
	logic [4:0]  best_changes_q;
	logic [7:0]  progress_q;

	logic               in_fire;
	logic               fin_fire;
	logic               rd_more;
	logic [RW-1:0]      win_ext;
	logic [RW-1:0]      wl_ext;
	logic [RW-1:0]      held_inc;
	logic [RW-1:0]      held_new_ext;
	logic [CNT_W-1:0]   held_new;
	logic [PW-1:0]      start_sum;
	logic [PW-1:0]      start_adj;
	logic [AW-1:0]      wp_next;
	logic [AW-1:0]      rd_addr_next;
	logic [ENTRY_W-1:0] wr_entry;
	logic [ENTRY_W-1:0] rd_entry;

	logic [CNT_W-1:0] l_raised, r_raised, l_changes, r_changes;
	logic [15:0]      l_swing, r_swing;
	logic             wave_l, wave_r, r_better, positive;
	logic [RW-1:0]    sel_raised, sel_changes;
	logic [15:0]      sel_swing;
	logic [7:0]       streak_inc;
	logic             alarm_n, started, release_now;
	logic [7:0]       streak_n;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= RST_ENABLE;
			window_length_q <= RST_WINDOW_LENGTH;
			min_raised_q    <= RST_MIN_RAISED;
			min_swing_q     <= RST_MIN_SWING;
			min_changes_q   <= RST_MIN_CHANGES;
			reset_frames_q  <= RST_RESET_FRAMES;
		end else if (wr_en) begin
			case (wr_index)
				CFG_ENABLE:        enable_q        <= wr_data[0];
				CFG_WINDOW_LENGTH: window_length_q <= wr_data[5:0];
				CFG_MIN_RAISED:    min_raised_q    <= wr_data[5:0];
				CFG_MIN_SWING:     min_swing_q     <= wr_data[14:0];
				CFG_MIN_CHANGES:   min_changes_q   <= wr_data[4:0];
				CFG_RESET_FRAMES:  reset_frames_q  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign in_fire       = samples.valid && samples.ready;

	// window fill and oldest entry
	assign win_ext      = RW'(window_length_q);
	assign wl_ext       = (win_ext > RW'(W)) ? RW'(W) : win_ext;
	assign held_inc     = RW'(held_q) + 1'b1;
	assign held_new_ext = (held_inc > wl_ext) ? wl_ext : held_inc;
	assign held_new     = held_new_ext[CNT_W-1:0];
	assign start_sum    = PW'(wp_q) + PW'(W) + PW'(1) - PW'(held_new);
	assign start_adj    = (start_sum >= PW'(W)) ? start_sum - PW'(W) : start_sum;
	assign wp_next      = (wp_q == AW'(W - 1)) ? '0 : wp_q + 1'b1;
	assign rd_addr_next = (rd_addr_q == AW'(W - 1)) ? '0 : rd_addr_q + 1'b1;
	assign rd_more      = (issue_q != held_q);

	assign wr_entry = {samples.left_raised, samples.left_offset,
		samples.right_raised, samples.right_offset};

	wga_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(W)
	) u_ram (
		.clk   (clk),
		.we    (in_fire),
		.waddr (wp_q),
		.wdata (wr_entry),
		.raddr (rd_addr_q),
		.rdata (rd_entry)
	);

	wga_hand #(.CNT_W(CNT_W)) u_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (in_fire),
		.vld        (vld_s1),
		.raised     (rd_entry[ENTRY_W-1]),
		.offset     (rd_entry[ENTRY_W-2 -: OFF_W]),
		.min_swing  (min_swing_q),
		.raised_cnt (l_raised),
		.swing      (l_swing),
		.changes    (l_changes)
	);

	wga_hand #(.CNT_W(CNT_W)) u_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (in_fire),
		.vld        (vld_s1),
		.raised     (rd_entry[OFF_W]),
		.offset     (rd_entry[OFF_W-1:0]),
		.min_swing  (min_swing_q),
		.raised_cnt (r_raised),
		.swing      (r_swing),
		.changes    (r_changes)
	);

	// decision
	assign wave_l = (RW'(l_raised) >= RW'(min_raised_q)) && (l_swing >= 16'(min_swing_q))
		&& (RW'(l_changes) >= RW'(min_changes_q));
	assign wave_r = (RW'(r_raised) >= RW'(min_raised_q)) && (r_swing >= 16'(min_swing_q))
		&& (RW'(r_changes) >= RW'(min_changes_q));
	assign positive = enable_q && (wave_l || wave_r);

	assign r_better = (r_raised > l_raised) || ((r_raised == l_raised) &&
		((r_swing > l_swing) || ((r_swing == l_swing) && (r_changes > l_changes))));

	assign streak_inc = (streak_q == 8'hFF) ? 8'hFF : streak_q + 1'b1;

	always_comb begin
		alarm_n     = alarm_q;
		streak_n    = streak_q;
		started     = 1'b0;
		release_now = 1'b0;
		if (!alarm_q && positive) begin
			alarm_n  = 1'b1;
			streak_n = '0;
			started  = 1'b1;
		end else if (alarm_q && positive) begin
			streak_n = '0;
		end else if (alarm_q) begin
			if (streak_inc >= reset_frames_q) begin
				alarm_n     = 1'b0;
				streak_n    = '0;
				release_now = 1'b1;
			end else begin
				streak_n = streak_inc;
			end
		end
	end

	always_comb begin
		if (release_now) begin
			sel_raised  = '0;
			sel_swing   = '0;
			sel_changes = '0;
		end else if (r_better) begin
			sel_raised  = RW'(r_raised);
			sel_swing   = r_swing;
			sel_changes = RW'(r_changes);
		end else begin
			sel_raised  = RW'(l_raised);
			sel_swing   = l_swing;
			sel_changes = RW'(l_changes);
		end
	end

	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || results.ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			held_q      <= '0;
			issue_q     <= '0;
			rd_addr_q   <= '0;
			vld_s1      <= 1'b0;
			alarm_q     <= 1'b0;
			streak_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						wp_q      <= wp_next;
						held_q    <= held_new;
						issue_q   <= '0;
						rd_addr_q <= start_adj[AW-1:0];
						state_q   <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (rd_more) begin
						issue_q   <= issue_q + 1'b1;
						rd_addr_q <= rd_addr_next;
						vld_s1    <= 1'b1;
					end else if (!vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						alarm_q  <= alarm_n;
						streak_q <= streak_n;
						if (release_now) begin
							held_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (fin_fire) begin
			positive_q     <= positive;
			active_q       <= alarm_n;
			started_q      <= started;
			best_raised_q  <= (sel_raised > RW'(63)) ? 6'd63 : sel_raised[5:0];
			best_swing_q   <= sel_swing;
			best_changes_q <= (sel_changes > RW'(31)) ? 5'd31 : sel_changes[4:0];
			progress_q     <= alarm_n ? streak_n : 8'd0;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.wave_positive    = positive_q;
	assign results.alarm_active     = active_q;
	assign results.alarm_started    = started_q;
	assign results.best_raised      = best_raised_q;
	assign results.best_swing       = best_swing_q;
	assign results.best_changes     = best_changes_q;
	assign results.release_progress = progress_q;

	`WGA_ASSERT_NOW(a_held_bound, 1'b1, held_q <= CNT_W'(W), "fill count beyond depth")
	`WGA_ASSERT_NEXT(a_accept_walk, in_fire, state_q == ST_WALK && issue_q == '0,
		"no walk after accept")
	`WGA_ASSERT_NOW(a_started_active, results.valid && results.alarm_started,
		results.alarm_active, "start without alarm")
	`WGA_ASSERT_NOW(a_progress_active, results.valid && results.release_progress != 8'd0,
		results.alarm_active, "progress without alarm")
	`WGA_ASSERT_NEXT(a_release_clears, fin_fire && release_now, held_q == '0 && !alarm_q,
		"release left history")

endmodule

`default_nettype wire

// ===== tb/wave_alarm_checker.sv =====
`timescale 1ns / 1ps

module wave_alarm_checker #(
	parameter int WINDOW_MAX = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	wga_in_if                              samples,
	wga_out_if                             results,
	input  logic                           wr_en,
	input  logic [wga_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [wga_pkg::CFG_DATA_W-1:0] wr_data,
	output int                             mismatches,
	output int                             pending,
	output int                             frames_checked,
	output int                             positives,
	output int                             alarm_starts
);
	import wga_pkg::*;

	typedef struct {
		int raised;
		int swing;
		int changes;
	} hand_stats_t;

	typedef struct packed {
		logic        wave_positive;
		logic        alarm_active;
		logic        alarm_started;
		logic [5:0]  best_raised;
		logic [15:0] best_swing;
		logic [4:0]  best_changes;
		logic [7:0]  release_progress;
	} frame_result_t;

	frame_result_t expected_frames[$];
	frame_result_t head_frame;

	logic        cfg_enable;
	logic [5:0]  cfg_window;
	logic [5:0]  cfg_min_raised;
	logic [14:0] cfg_min_swing;
	logic [4:0]  cfg_min_changes;
	logic [7:0]  cfg_reset_frames;

	bit hist_raised[2][WINDOW_MAX];
	int hist_offset[2][WINDOW_MAX];
	int write_pos;
	int held_count;
	int negative_streak;
	bit alarm_on;

	function automatic hand_stats_t measure_hand(input int hand);
		hand_stats_t s;
		int lo, hi, prev, d, ad, dir, last_dir, idx, v, k;
		s.raised = 0;
		s.swing = 0;
		s.changes = 0;
		lo = 0;
		hi = 0;
		prev = 0;
		last_dir = 0;
		for (k = 0; k < held_count; k++) begin
			idx = (write_pos + WINDOW_MAX - held_count + k) % WINDOW_MAX;
			if (hist_raised[hand][idx]) begin
				v = hist_offset[hand][idx];
				if (s.raised == 0) begin
					lo = v;
					hi = v;
				end else begin
					d = v - prev;
					ad = d < 0 ? -d : d;
					if (v < lo)
						lo = v;
					if (v > hi)
						hi = v;
					if (ad >= STEP_FLOOR && 5 * ad >= int'(cfg_min_swing)) begin
						dir = d > 0 ? 1 : -1;
						if (last_dir != 0 && dir != last_dir)
							s.changes++;
						last_dir = dir;
					end
				end
				prev = v;
				s.raised++;
			end
		end
		s.swing = hi - lo;
		return s;
	endfunction

	function automatic bit hand_waving(input hand_stats_t s);
		return s.raised >= int'(cfg_min_raised) && s.swing >= int'(cfg_min_swing) &&
			s.changes >= int'(cfg_min_changes);
	endfunction

	function automatic bit outranks(input hand_stats_t a, input hand_stats_t b);
		if (a.raised != b.raised)
			return a.raised > b.raised;
		if (a.swing != b.swing)
			return a.swing > b.swing;
		return a.changes > b.changes;
	endfunction

	function automatic frame_result_t advance_frame(input logic lr, input int lo, input logic rr,
		input int ro);
		int wl;
		hand_stats_t ls, rs, best;
		bit positive, started;
		frame_result_t r;
		wl = int'(cfg_window) > WINDOW_MAX ? WINDOW_MAX : int'(cfg_window);
		started = 1'b0;
		hist_raised[0][write_pos] = lr;
		hist_offset[0][write_pos] = lo;
		hist_raised[1][write_pos] = rr;
		hist_offset[1][write_pos] = ro;
		write_pos = (write_pos + 1) % WINDOW_MAX;
		held_count = held_count + 1 > wl ? wl : held_count + 1;
		ls = measure_hand(0);
		rs = measure_hand(1);
		positive = cfg_enable && (hand_waving(ls) || hand_waving(rs));
		if (!alarm_on && positive) begin
			alarm_on = 1'b1;
			negative_streak = 0;
			started = 1'b1;
		end else if (alarm_on && positive) begin
			negative_streak = 0;
		end else if (alarm_on) begin
			if (negative_streak < 255)
				negative_streak++;
			if (negative_streak >= int'(cfg_reset_frames)) begin
				alarm_on = 1'b0;
				negative_streak = 0;
				held_count = 0;
				ls = measure_hand(0);
				rs = measure_hand(1);
			end
		end
		best = ls;
		if (outranks(rs, best))
			best = rs;
		r.wave_positive = positive;
		r.alarm_active = alarm_on;
		r.alarm_started = started;
		r.best_raised = best.raised > 63 ? 6'd63 : 6'(best.raised);
		r.best_swing = 16'(best.swing);
		r.best_changes = best.changes > 31 ? 5'd31 : 5'(best.changes);
		r.release_progress = alarm_on ? 8'(negative_streak) : 8'd0;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("result word %0d: %s", frames_checked, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_enable = RST_ENABLE;
			cfg_window = RST_WINDOW_LENGTH;
			cfg_min_raised = RST_MIN_RAISED;
			cfg_min_swing = RST_MIN_SWING;
			cfg_min_changes = RST_MIN_CHANGES;
			cfg_reset_frames = RST_RESET_FRAMES;
			for (int i = 0; i < WINDOW_MAX; i++) begin
				hist_raised[0][i] = 1'b0;
				hist_raised[1][i] = 1'b0;
				hist_offset[0][i] = 0;
				hist_offset[1][i] = 0;
			end
			write_pos = 0;
			held_count = 0;
			negative_streak = 0;
			alarm_on = 1'b0;
			expected_frames.delete();
			mismatches = 0;
			frames_checked = 0;
			positives = 0;
			alarm_starts = 0;
			pending <= 0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_frames.size() == 0) begin
					report_mismatch("result word with no frame outstanding");
				end else begin
					head_frame = expected_frames[0];
					expected_frames.delete(0);
					check_field("wave_positive", results.wave_positive, head_frame.wave_positive);
					check_field("alarm_active", results.alarm_active, head_frame.alarm_active);
					check_field("alarm_started", results.alarm_started, head_frame.alarm_started);
					check_field("best_raised", results.best_raised, head_frame.best_raised);
					check_field("best_swing", results.best_swing, head_frame.best_swing);
					check_field("best_changes", results.best_changes, head_frame.best_changes);
					check_field("release_progress", results.release_progress,
						head_frame.release_progress);
				end
				frames_checked++;
			end
			if (samples.valid && samples.ready) begin
				head_frame = advance_frame(samples.left_raised, int'($signed(samples.left_offset)),
					samples.right_raised, int'($signed(samples.right_offset)));
				expected_frames = {expected_frames, head_frame};
				positives += head_frame.wave_positive;
				alarm_starts += head_frame.alarm_started;
			end
			if (wr_en) begin
				case (wr_index)
					CFG_ENABLE:        cfg_enable = wr_data[0];
					CFG_WINDOW_LENGTH: cfg_window = wr_data[5:0];
					CFG_MIN_RAISED:    cfg_min_raised = wr_data[5:0];
					CFG_MIN_SWING:     cfg_min_swing = wr_data[14:0];
					CFG_MIN_CHANGES:   cfg_min_changes = wr_data[4:0];
					CFG_RESET_FRAMES:  cfg_reset_frames = wr_data[7:0];
					default: ;
				endcase
			end
			pending <= expected_frames.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import wga_pkg::*;

	localparam int WINDOW_MAX = 32;
	localparam int PHASES = 12;
	localparam int PHASE_FRAMES = 150;
	localparam int SETTLE_CYCLES = WINDOW_MAX + 4;
	localparam int LONG_HOLD = 400;
	localparam int STALL_LIMIT = 4000;

	typedef enum int {HAND_WAVE, HAND_NOISE, HAND_REST} hand_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	int frames_sent = 0;

	int mismatches;
	int pending;
	int frames_checked;
	int positives;
	int alarm_starts;

	hand_mode_t hand_mode[2];
	int seq_left[2];
	int center[2];
	int swing_amp[2];
	int dwell[2];
	int dwell_cnt[2];
	int last_off[2];
	bit high_side[2];

	wga_in_if samples();
	wga_out_if results();

	wave_gesture_alarm #(
		.WINDOW_MAX(WINDOW_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.results(results),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	wave_alarm_checker #(
		.WINDOW_MAX(WINDOW_MAX)
	) frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.results(results),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.mismatches(mismatches),
		.pending(pending),
		.frames_checked(frames_checked),
		.positives(positives),
		.alarm_starts(alarm_starts)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (hold_left > 0) begin
			results.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_requests != holds_served) begin
			results.ready <= 1'b0;
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD;
		end else begin
			results.ready <= $urandom_range(99) >= rx_idle_pct;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (results.valid && results.ready) ||
			wr_en) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_frame(input bit lr, input int lo, input bit rr, input int ro);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.left_raised <= lr;
		samples.left_offset <= 16'(lo);
		samples.right_raised <= rr;
		samples.right_offset <= 16'(ro);
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		frames_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	task automatic apply_settings(input int en, input int wl, input int mr, input int ms,
		input int mc, input int rf);
		write_reg(CFG_ENABLE, en);
		write_reg(CFG_WINDOW_LENGTH, wl);
		write_reg(CFG_MIN_RAISED, mr);
		write_reg(CFG_MIN_SWING, ms);
		write_reg(CFG_MIN_CHANGES, mc);
		write_reg(CFG_RESET_FRAMES, rf);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_results();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic next_hand(input int h, output bit raised, output int off);
		int pick;
		if (seq_left[h] == 0) begin
			pick = $urandom_range(99);
			hand_mode[h] = pick < 55 ? HAND_WAVE : pick < 75 ? HAND_NOISE : HAND_REST;
			seq_left[h] = $urandom_range(40, 4);
			center[h] = int'($urandom_range(16000)) - 8000;
			swing_amp[h] = $urandom_range(9) == 0 ? $urandom_range(20000) : $urandom_range(3000, 40);
			dwell[h] = $urandom_range(3, 1);
			dwell_cnt[h] = 0;
		end
		seq_left[h]--;
		case (hand_mode[h])
			HAND_WAVE: begin
				raised = $urandom_range(19) != 0;
				off = center[h] + (high_side[h] ? swing_amp[h] : -swing_amp[h]) +
					int'($urandom_range(60)) - 30;
				dwell_cnt[h]++;
				if (dwell_cnt[h] >= dwell[h]) begin
					dwell_cnt[h] = 0;
					high_side[h] = !high_side[h];
				end
			end
			HAND_NOISE: begin
				raised = $urandom_range(1) != 0;
				if ($urandom_range(1))
					off = $signed(16'($urandom));
				else
					off = last_off[h] + int'($urandom_range(200)) - 100;
			end
			default: begin
				raised = $urandom_range(29) == 0;
				off = $signed(16'($urandom));
			end
		endcase
		if (off > 32767)
			off = 32767;
		if (off < -32768)
			off = -32768;
		last_off[h] = off;
	endtask

	task automatic random_frame();
		bit lr, rr;
		int lo, ro;
		next_hand(0, lr, lo);
		next_hand(1, rr, ro);
		send_frame(lr, lo, rr, ro);
	endtask

	initial begin
		int ph, n;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		samples.valid = 1'b0;
		samples.left_raised = 1'b0;
		samples.left_offset = '0;
		samples.right_raised = 1'b0;
		samples.right_offset = '0;
		results.ready = 1'b0;
		seq_left[0] = 0;
		seq_left[1] = 0;
		high_side[0] = 1'b0;
		high_side[1] = 1'b1;
		last_off[0] = 0;
		last_off[1] = 0;
		tx_idle_pct = 19;
		rx_idle_pct = 59;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, ignored offsets, step floor and a left-hand wave
		apply_settings(RST_ENABLE, RST_WINDOW_LENGTH, RST_MIN_RAISED, RST_MIN_SWING,
			RST_MIN_CHANGES, RST_RESET_FRAMES);
		send_frame(1, -32768, 1, 32767);
		send_frame(1, 32767, 1, -32768);
		send_frame(0, 32767, 0, -32768);
		send_frame(1, 0, 1, 0);
		send_frame(1, 81, 1, 82);
		send_frame(1, 0, 1, 0);
		for (n = 0; n < 4; n++)
			send_frame(1, n % 2 ? -700 : 700, 0, 0);
		settle();
		// shrink window under an active alarm, immediate release
		apply_settings(1, 2, 3, 1229, 2, 0);
		send_frame(0, 0, 0, 0);
		send_frame(0, 0, 0, 0);
		settle();
		// step exactly at min_swing / 5
		apply_settings(1, 8, 3, 500, 1, 2);
		send_frame(1, 0, 0, 0);
		send_frame(1, 100, 0, 0);
		send_frame(1, 0, 0, 0);
		send_frame(1, 99, 0, 0);
		send_frame(1, 0, 0, 0);
		settle();
		apply_settings(0, 1, 0, 0, 0, 0);
		send_frame(1, 5, 1, -5);
		send_frame(1, -5, 1, 5);
		settle();
		// empty window with zero thresholds waves
		apply_settings(1, 0, 0, 0, 0, 0);
		send_frame(1, 100, 0, 0);
		settle();
		apply_settings(1, 0, 1, 0, 0, 0);
		send_frame(1, 100, 1, 100);
		settle();

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 4) begin
				tx_idle_pct <= 59;
				rx_idle_pct <= 19;
			end else if (ph == 8) begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end
			case (ph)
				0: apply_settings(RST_ENABLE, RST_WINDOW_LENGTH, RST_MIN_RAISED, RST_MIN_SWING,
					RST_MIN_CHANGES, RST_RESET_FRAMES);
				1: apply_settings(1, 0, 0, 0, 0, 0);
				2: apply_settings(0, 32, 32, 32767, 31, 255);
				5: apply_settings(1, 63, 1, 0, 0, 1);
				9: apply_settings(1, 32, 0, 32767, 0, 3);
				default: apply_settings($urandom_range(7) != 0,
					$urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(32, 3),
					$urandom_range(10), $urandom_range(3000), $urandom_range(5),
					$urandom_range(20));
			endcase
			for (n = 0; n < PHASE_FRAMES; n++) begin
				if ((ph == 1 || ph == 9) && n == 40)
					hold_requests <= hold_requests + 1;
				if (ph == 6 && n == 75)
					wait_results();
				random_frame();
			end
			settle();
		end

		$display("%0d frames sent over %0d register settings, %0d result words compared",
			frames_sent, PHASES + 6, frames_checked);
		$display("%0d wave detections and %0d alarm onsets under mixed, inverted and no idling",
			positives, alarm_starts);
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== wave_gesture_alarm.f =====
+incdir+rtl
rtl/wga_pkg.sv
rtl/wga_if.sv
rtl/wga_ram.sv
rtl/wga_hand.sv
rtl/wave_gesture_alarm.sv
tb/wave_alarm_checker.sv
tb/testbench.sv
